// File: hw/rtl/idiv32_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package idiv32_pkg;

  // width of the operand and result ports
  localparam int XLEN = 32;
  localparam int CMD_W = 2;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_SQUO = 2'd0,
    CMD_SREM = 2'd1,
    CMD_UQUO = 2'd2,
    CMD_UREM = 2'd3
  } idiv_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX
  } idiv_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/integer_divider_32.sv
// channel | ports                                         | direction
// in      | in_valid, in_ready, in_command, in_dividend,  | word in
//         | in_divisor                                    |
// out     | out_valid, out_ready, out_result              | word out
//
// each word is handled in order: the operands and their magnitudes are taken,
// the shared subtract/compare unit forms the quotient bits one at a time, and
// the sign fix-up writes the output register; no new word is taken until idle.
// in_ready is high whenever the sequencer is idle, even while a result waits.
// a finished result waits in the fix-up cycle if the output register is full.
// rst_n is synchronous; it clears the sequencer and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module integer_divider_32
  import idiv32_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [CMD_W-1:0] in_command,
  input  wire logic [XLEN-1:0]  in_dividend,
  input  wire logic [XLEN-1:0]  in_divisor,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [XLEN-1:0]       out_result
);

  localparam int CNT_W = $clog2(DATA_WIDTH);

  idiv_state_t state_r, state_nxt;

  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] quo_r, quo_nxt;
  logic [DATA_WIDTH-1:0] div_r, div_nxt;
  logic                  neg_q_r, neg_q_nxt;
  logic                  neg_r_r, neg_r_nxt;
  logic                  sel_rem_r, sel_rem_nxt;
  logic                  dzero_r, dzero_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [XLEN-1:0]       out_result_r, out_result_nxt;

  logic                  in_fire;
  logic                  fix_fire;
  logic                  step_en;

  logic [DATA_WIDTH-1:0] a_w, b_w, a_mag, b_mag;
  logic                  is_signed, a_neg, b_neg;

  logic                  carry;
  logic [DATA_WIDTH-1:0] rem_sh;
  logic [DATA_WIDTH:0]   diff;
  logic                  ge;

  logic [DATA_WIDTH-1:0] mag;
  logic [DATA_WIDTH-1:0] res_w;
  logic                  neg_sel;

  // operand magnitudes
  always_comb begin
    a_w = DATA_WIDTH'(in_dividend);
    b_w = DATA_WIDTH'(in_divisor);
    is_signed = (in_command == CMD_SQUO) || (in_command == CMD_SREM);
    a_neg = is_signed & a_w[DATA_WIDTH-1];
    b_neg = is_signed & b_w[DATA_WIDTH-1];
    a_mag = a_neg ? (~a_w + 1'b1) : a_w;
    b_mag = b_neg ? (~b_w + 1'b1) : b_w;
  end

  // shared restoring step: shift in next dividend bit, trial subtract
  always_comb begin
    carry  = rem_r[DATA_WIDTH-1];
    rem_sh = {rem_r[DATA_WIDTH-2:0], quo_r[DATA_WIDTH-1]};
    diff   = {carry, rem_sh} - {1'b0, div_r};
    ge     = ~diff[DATA_WIDTH];
  end

  // sign fix-up; zero divisor forces quotient 0 (remainder is already the dividend)
  always_comb begin
    mag     = sel_rem_r ? rem_r : (dzero_r ? '0 : quo_r);
    neg_sel = sel_rem_r ? neg_r_r : neg_q_r;
    res_w   = neg_sel ? (~mag + 1'b1) : mag;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == '0) state_nxt = ST_FIX;
      end
      ST_FIX: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    step_en  = 1'b0;
    fix_fire = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_DIV:  step_en  = 1'b1;
      ST_FIX:  fix_fire = !out_valid_r || out_ready;
      default: in_ready = 1'b0;
    endcase
  end

  assign in_fire = in_valid & in_ready;

  // datapath next values
  always_comb begin
    cnt_nxt        = cnt_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    div_nxt        = div_r;
    neg_q_nxt      = neg_q_r;
    neg_r_nxt      = neg_r_r;
    sel_rem_nxt    = sel_rem_r;
    dzero_nxt      = dzero_r;
    out_result_nxt = out_result_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    if (in_fire) begin
      cnt_nxt     = CNT_W'(DATA_WIDTH - 1);
      rem_nxt     = '0;
      quo_nxt     = a_mag;
      div_nxt     = b_mag;
      neg_q_nxt   = a_neg ^ b_neg;
      neg_r_nxt   = a_neg;
      sel_rem_nxt = (in_command == CMD_SREM) || (in_command == CMD_UREM);
      dzero_nxt   = (b_w == '0);
    end
    if (step_en) begin
      cnt_nxt = cnt_r - 1'b1;
      rem_nxt = ge ? diff[DATA_WIDTH-1:0] : rem_sh;
      quo_nxt = {quo_r[DATA_WIDTH-2:0], ge};
    end
    if (fix_fire) begin
      out_result_nxt = XLEN'(res_w);
      out_valid_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    div_r        <= div_nxt;
    neg_q_r      <= neg_q_nxt;
    neg_r_r      <= neg_r_nxt;
    sel_rem_r    <= sel_rem_nxt;
    dzero_r      <= dzero_nxt;
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

`default_nettype wire

// File: hw/rtl/idiv32_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module idiv32_chk
  import idiv32_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic [CMD_W-1:0] in_command,
  input wire logic [XLEN-1:0]  in_dividend,
  input wire logic [XLEN-1:0]  in_divisor,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [XLEN-1:0]  out_result
);

  logic in_word_seen;

  assign in_word_seen = in_valid && in_ready && (in_command == in_command)
                        && (in_dividend == in_dividend) && (in_divisor == in_divisor);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("result changed or dropped while stalled");

  // busy right after taking a word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_word_seen |=> !in_ready)
    else $error("ready right after accept");

  // a result never rises in the cycle after its word came in
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_word_seen |=> !$rose(out_valid))
    else $error("result appeared too early");

  // a new result lands together with the return to idle
  a_rise_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result registered while still busy");

endmodule

bind integer_divider_32 idiv32_chk u_idiv32_chk (.*);

`default_nettype wire
